FILE: src/endl_pkg.sv
// Package for the ELF note descriptor locator.
// Holds the walk phase codes, register indexes, result type and the name tag table.
// No dependencies.
package endl_pkg;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_NAME   = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    localparam logic REG_BIG_ENDIAN = 1'b0;
    localparam logic REG_WIDE_CLASS = 1'b1;

    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_NONE  = 1'b1;

    // Index of the terminating NUL of each name, and the header length less one.
    localparam logic [3:0] PLAIN_LAST  = 4'd10;
    localparam logic [3:0] XEN_LAST    = 4'd14;
    localparam logic [3:0] HEADER_LAST = 4'd11;

    typedef struct packed {
        logic        status;
        logic [31:0] desc_offset;
        logic [31:0] desc_size;
        logic        xen_seen;
    } result_t;

    // Bytes of the Xen note name and its NUL. The plain name shares the first ten.
    function automatic logic [7:0] tag_xen_byte(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0:    c = 8'h56;
            4'd1:    c = 8'h4D;
            4'd2:    c = 8'h43;
            4'd3:    c = 8'h4F;
            4'd4:    c = 8'h52;
            4'd5:    c = 8'h45;
            4'd6:    c = 8'h49;
            4'd7:    c = 8'h4E;
            4'd8:    c = 8'h46;
            4'd9:    c = 8'h4F;
            4'd10:   c = 8'h5F;
            4'd11:   c = 8'h58;
            4'd12:   c = 8'h45;
            4'd13:   c = 8'h4E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] tag_plain_byte(input logic [3:0] i);
        logic [7:0] c;
        if (i == PLAIN_LAST)
        begin
            c = 8'h00;
        end
        else
        begin
            c = tag_xen_byte(i);
        end
        return c;
    endfunction

    // Round up to a multiple of four, wrapping in 32 bits.
    function automatic logic [31:0] pad4(input logic [31:0] v);
        logic [31:0] s;
        s = v + 32'd3;
        return {s[31:2], 2'b00};
    endfunction

endpackage

FILE: src/endl_in_if.sv
// Input channel of the ELF note descriptor locator: one segment byte per transfer.
// No dependencies.
interface endl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: src/endl_out_if.sv
// Result channel of the ELF note descriptor locator: one answer per segment.
// No dependencies.
interface endl_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [31:0] desc_offset;
    logic [31:0] desc_size;
    logic        xen_seen;

    modport source (output valid, output status, output desc_offset, output desc_size,
                    output xen_seen, input ready);
    modport sink   (input valid, input status, input desc_offset, input desc_size,
                    input xen_seen, output ready);
endinterface

FILE: src/endl_walker.sv
// Note walk state and per-byte next-state logic of the ELF note descriptor locator.
// Depends on endl_pkg.
module endl_walker
    import endl_pkg::*;
#(
    parameter int POSITION_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       big_endian,
    output logic       emit,
    output result_t    result
);

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] header_word_reg, header_word_next;
    logic [31:0] name_length_reg, name_length_next;
    logic [31:0] body_length_reg, body_length_next;
    logic [31:0] skip_reg, skip_next;
    logic [3:0]  index_reg, index_next;
    logic        plain_live_reg, plain_live_next;
    logic        xen_live_reg, xen_live_next;
    logic [31:0] found_offset_reg, found_offset_next;
    logic [31:0] found_size_reg, found_size_next;
    logic        xen_flag_reg, xen_flag_next;
    logic        done_reg, done_next;

    logic [31:0] skip_dec;
    logic [31:0] word_acc;
    logic [31:0] pad_name;
    logic [31:0] pad_body;
    logic [31:0] desc_here;
    logic        plain_hit;
    logic        xen_hit;

    assign skip_dec  = skip_reg - 32'd1;
    assign pad_name  = pad4(name_length_reg);
    assign pad_body  = pad4(body_length_reg);
    // Descriptor starts after the rest of the padded name field.
    assign desc_here = 32'(pos_reg + POSITION_BITS'(skip_dec) + POSITION_BITS'(1));
    assign plain_hit = plain_live_reg && (index_reg <= PLAIN_LAST)
                       && (data_byte == tag_plain_byte(index_reg));
    assign xen_hit   = xen_live_reg && (index_reg <= XEN_LAST)
                       && (data_byte == tag_xen_byte(index_reg));

    always_comb
    begin
        if (big_endian)
        begin
            word_acc = {header_word_reg[23:0], data_byte};
        end
        else
        begin
            word_acc = header_word_reg | (32'(data_byte) << {index_reg[1:0], 3'b000});
        end
    end

    always_comb
    begin
        pos_next          = pos_reg + POSITION_BITS'(1);
        phase_next        = phase_reg;
        header_word_next  = header_word_reg;
        name_length_next  = name_length_reg;
        body_length_next  = body_length_reg;
        skip_next         = skip_reg;
        index_next        = index_reg;
        plain_live_next   = plain_live_reg;
        xen_live_next     = xen_live_reg;
        found_offset_next = found_offset_reg;
        found_size_next   = found_size_reg;
        xen_flag_next     = xen_flag_reg;
        done_next         = done_reg;
        emit              = 1'b0;
        result            = '{status: STATUS_NONE, desc_offset: 32'd0, desc_size: 32'd0,
                              xen_seen: 1'b0};

        if (!done_reg)
        begin
            case (phase_reg)
                PH_NAME:
                begin
                    skip_next       = skip_dec;
                    plain_live_next = plain_hit;
                    xen_live_next   = xen_hit;
                    if (index_reg < 4'd15)
                    begin
                        index_next = index_reg + 4'd1;
                    end
                    if (index_reg == PLAIN_LAST && plain_hit)
                    begin
                        emit            = 1'b1;
                        result          = '{status: STATUS_FOUND, desc_offset: desc_here,
                                            desc_size: body_length_reg,
                                            xen_seen: xen_flag_reg};
                        done_next       = 1'b1;
                        plain_live_next = 1'b0;
                        xen_live_next   = 1'b0;
                    end
                    else if (index_reg == XEN_LAST && xen_hit)
                    begin
                        found_offset_next = desc_here;
                        found_size_next   = body_length_reg;
                        xen_flag_next     = 1'b1;
                        xen_live_next     = 1'b0;
                    end
                    if (!done_next && skip_dec == 32'd0)
                    begin
                        plain_live_next  = 1'b0;
                        xen_live_next    = 1'b0;
                        index_next       = 4'd0;
                        header_word_next = 32'd0;
                        skip_next        = pad_body;
                        phase_next       = (pad_body != 32'd0) ? PH_BODY : PH_HEADER;
                    end
                end
                PH_BODY:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0)
                    begin
                        phase_next       = PH_HEADER;
                        index_next       = 4'd0;
                        header_word_next = 32'd0;
                    end
                end
                default:
                begin
                    phase_next       = PH_HEADER;
                    header_word_next = word_acc;
                    if (index_reg[1:0] == 2'd3)
                    begin
                        if (index_reg == 4'd3)
                        begin
                            name_length_next = word_acc;
                        end
                        else if (index_reg == 4'd7)
                        begin
                            body_length_next = word_acc;
                        end
                        header_word_next = 32'd0;
                    end
                    if (index_reg >= HEADER_LAST)
                    begin
                        index_next = 4'd0;
                        if (pad_name != 32'd0)
                        begin
                            skip_next       = pad_name;
                            phase_next      = PH_NAME;
                            plain_live_next = 1'b1;
                            xen_live_next   = 1'b1;
                        end
                        else
                        begin
                            // Empty name: straight on to the descriptor.
                            plain_live_next  = 1'b0;
                            xen_live_next    = 1'b0;
                            header_word_next = 32'd0;
                            skip_next        = pad_body;
                            phase_next       = (pad_body != 32'd0) ? PH_BODY : PH_HEADER;
                        end
                    end
                    else
                    begin
                        index_next = index_reg + 4'd1;
                    end
                end
            endcase
        end

        if (last_byte)
        begin
            if (!emit && !done_reg)
            begin
                emit = 1'b1;
                if (xen_flag_next)
                begin
                    result = '{status: STATUS_FOUND, desc_offset: found_offset_next,
                               desc_size: found_size_next, xen_seen: 1'b1};
                end
            end
            pos_next          = '0;
            phase_next        = PH_HEADER;
            header_word_next  = 32'd0;
            name_length_next  = 32'd0;
            body_length_next  = 32'd0;
            skip_next         = 32'd0;
            index_next        = 4'd0;
            plain_live_next   = 1'b0;
            xen_live_next     = 1'b0;
            found_offset_next = 32'd0;
            found_size_next   = 32'd0;
            xen_flag_next     = 1'b0;
            done_next         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            phase_reg        <= PH_HEADER;
            header_word_reg  <= 32'd0;
            name_length_reg  <= 32'd0;
            body_length_reg  <= 32'd0;
            skip_reg         <= 32'd0;
            index_reg        <= 4'd0;
            plain_live_reg   <= 1'b0;
            xen_live_reg     <= 1'b0;
            found_offset_reg <= 32'd0;
            found_size_reg   <= 32'd0;
            xen_flag_reg     <= 1'b0;
            done_reg         <= 1'b0;
        end
        else if (step)
        begin
            pos_reg          <= pos_next;
            phase_reg        <= phase_next;
            header_word_reg  <= header_word_next;
            name_length_reg  <= name_length_next;
            body_length_reg  <= body_length_next;
            skip_reg         <= skip_next;
            index_reg        <= index_next;
            plain_live_reg   <= plain_live_next;
            xen_live_reg     <= xen_live_next;
            found_offset_reg <= found_offset_next;
            found_size_reg   <= found_size_next;
            xen_flag_reg     <= xen_flag_next;
            done_reg         <= done_next;
        end
    end

endmodule

FILE: src/elf_note_descriptor_locator.sv
// Path: each byte waits in the input register; an answer is written to the result register.
// Throughput: one byte per cycle, set by the single walk step between the input
// register and the result register; an untaken result holds the walk and stalls the input.
// Reset: asynchronous, active low; clears the walk, both stages and the registers
// (big_endian 0, wide_class 1). No clearing pass is needed.
module elf_note_descriptor_locator
    import endl_pkg::*;
#(
    parameter int POSITION_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    endl_in_if.sink     in_ch,
    endl_out_if.source  out_ch
);

    logic       big_endian_reg;
    logic       wide_class_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg;
    logic       step;
    logic       emit;
    result_t    result;

    // A held byte advances the walk whenever the result register can take an answer.
    assign step         = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            big_endian_reg <= 1'b0;
            wide_class_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_BIG_ENDIAN)
            begin
                big_endian_reg <= cfg_data;
            end
            else
            begin
                wide_class_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_byte_reg <= in_ch.data_byte;
            in_last_reg <= in_ch.last_byte;
        end
    end

    endl_walker #(
        .POSITION_BITS (POSITION_BITS)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .big_endian (big_endian_reg),
        .emit       (emit),
        .result     (result)
    );

    always_comb
    begin
        if (step && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_data_reg.status;
    assign out_ch.desc_offset = out_data_reg.desc_offset;
    assign out_ch.desc_size   = out_data_reg.desc_size;
    assign out_ch.xen_seen    = out_data_reg.xen_seen;

    // The input side only stalls while a byte is held behind an untaken result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (in_valid_reg && out_valid_reg && !out_ch.ready))
        else $error("input stalled without a blocked result");

    // A not-found answer carries no descriptor and no Xen mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status == STATUS_NONE) |->
        (out_data_reg.desc_offset == 32'd0 && out_data_reg.desc_size == 32'd0
         && !out_data_reg.xen_seen))
        else $error("not-found answer with descriptor fields set");

    // An untaken result is never overwritten by a new answer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !step)
        else $error("walk advanced over a pending result");

    // The class register changes only on a write to its own index.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_we && cfg_index == REG_WIDE_CLASS) |=> $stable(wide_class_reg))
        else $error("class register changed without a write");

endmodule
